// ===== rtl/pbch_pkg.sv =====
// Shared types, codes and constants for the parity basis change histogram.
`timescale 1ns / 1ps

package pbch_pkg;

  // Default sizes
  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int BASIS_MAX_DEF   = 32;
  localparam int STATE_BITS_DEF  = 32;

  // Fixed field widths of the item ports
  localparam int REQ_W      = 2;
  localparam int SLOT_W     = 10;
  localparam int DATA_W     = 32;
  localparam int COUNT_W    = 32;
  localparam int IDX_OUT_W  = 10;
  localparam int USED_OUT_W = 11;
  localparam int STATUS_W   = 2;
  localparam int BC_W       = 6;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD  = 2'd0,
    REQ_ADD   = 2'd1,
    REQ_READ  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_SAT   = 2'd3
  } status_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;      // latch the accepted item
    logic load_basis;   // write one basis vector
    logic xform;        // compute the key and restart the search
    logic step;         // advance the linear search by one entry
    logic update;       // add the count into the matched entry
    logic append;       // append a new key, or flag a full table
    logic read_issue;   // start a table read at the requested slot
    logic read_finish;  // build the result of a table read
    logic clear;        // empty the table
    logic emit;         // move the finished result to the output register
  } pbch_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    req_t req;          // request type of the item in work
    logic hit;          // search found the key
    logic miss;         // search covered every used entry without a match
    logic out_free;     // output register can take a result this cycle
  } pbch_sts_t;

endpackage

// ===== rtl/pbch_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module pbch_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds when not reading
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/pbch_ctrl.sv =====
// Controller state machine that sequences each item through the datapath.
`timescale 1ns / 1ps

module pbch_ctrl import pbch_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  pbch_sts_t sts,
  output pbch_cmd_t cmd
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECODE = 7'b0000010,
    S_SEARCH = 7'b0000100,
    S_UPDATE = 7'b0001000,
    S_RDWAIT = 7'b0010000,
    S_EMIT   = 7'b0100000,
    S_SPARE  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // Take a new item only when no item is in work
  assign in_stall = (state_r != S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.req)
          REQ_LOAD: begin
            cmd.load_basis = 1'b1;
            state_nxt      = S_EMIT;
          end
          REQ_ADD: begin
            cmd.xform = 1'b1;
            state_nxt = S_SEARCH;
          end
          REQ_READ: begin
            cmd.read_issue = 1'b1;
            state_nxt      = S_RDWAIT;
          end
          REQ_CLEAR: begin
            cmd.clear = 1'b1;
            state_nxt = S_EMIT;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_SEARCH: begin
        cmd.step = 1'b1;
        if (sts.hit) begin
          state_nxt = S_UPDATE;
        end else if (sts.miss) begin
          cmd.append = 1'b1;
          state_nxt  = S_EMIT;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = S_EMIT;
      end
      S_RDWAIT: begin
        cmd.read_finish = 1'b1;
        state_nxt       = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/pbch_dp.sv =====
// Datapath: basis registers, key transform, key and count tables, result registers.
`timescale 1ns / 1ps

module pbch_dp import pbch_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int BASIS_MAX   = BASIS_MAX_DEF,
  parameter int STATE_BITS  = STATE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pbch_cmd_t             cmd,
  output pbch_sts_t             sts,
  input  logic                  cfg_wr_en,
  input  logic [BC_W-1:0]       cfg_wr_data,
  input  logic [REQ_W-1:0]      in_req_type,
  input  logic [SLOT_W-1:0]     in_slot,
  input  logic [DATA_W-1:0]     in_state_value,
  input  logic [COUNT_W-1:0]    in_occurrence_count,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DATA_W-1:0]     out_transformed_state,
  output logic [IDX_OUT_W-1:0]  out_entry_index,
  output logic [DATA_W-1:0]     out_entry_key,
  output logic [COUNT_W-1:0]    out_entry_count,
  output logic [USED_OUT_W-1:0] out_entries_used,
  output logic [STATUS_W-1:0]   out_status
);

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int CW    = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W = (CW > SLOT_W) ? CW : SLOT_W;
  localparam int KEY_W = BASIS_MAX;

  // Configuration and captured item
  logic [BC_W-1:0]       bcount_r;
  req_t                  req_r;
  logic [SLOT_W-1:0]     slot_r;
  logic [STATE_BITS-1:0] sval_r;
  logic [COUNT_W-1:0]    cnt_r;

  // Basis vectors, reset to zero
  logic [STATE_BITS-1:0] basis_r [BASIS_MAX];

  // Key of the add in work and search pointers
  logic [KEY_W-1:0] tkey_r, tkey_nxt;
  logic [BC_W-1:0]  bcount_eff;
  logic [CW-1:0]    used_r;
  logic [CW-1:0]    rd_idx_r;
  logic             cmp_vld_r;
  logic [AW-1:0]    cmp_idx_r;
  logic             more;
  logic             hit;
  logic             issue;

  // Table memories
  logic             key_we, cnt_we, rd_en;
  logic [AW-1:0]    waddr, raddr;
  logic [KEY_W-1:0] key_rdata;
  logic [COUNT_W-1:0] cnt_wdata, cnt_rdata;

  // Saturating add
  logic [COUNT_W:0]   sum;
  logic [COUNT_W-1:0] sum_sat;

  // Read range check
  logic slot_ok;

  // Finished result waiting for the output register
  logic [KEY_W-1:0]   res_tstate_r;
  logic [AW-1:0]      res_idx_r;
  logic [KEY_W-1:0]   res_key_r;
  logic [COUNT_W-1:0] res_count_r;
  status_t            res_status_r;

  // Output register
  logic                  out_valid_r;
  logic [DATA_W-1:0]     out_tstate_r;
  logic [IDX_OUT_W-1:0]  out_idx_r;
  logic [DATA_W-1:0]     out_key_r;
  logic [COUNT_W-1:0]    out_count_r;
  logic [USED_OUT_W-1:0] out_used_r;
  logic [STATUS_W-1:0]   out_status_r;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bcount_r <= '0;
    end else if (cfg_wr_en) begin
      bcount_r <= cfg_wr_data;
    end
  end

  // Capture the accepted item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r  <= req_t'(in_req_type);
      slot_r <= in_slot;
      sval_r <= in_state_value[STATE_BITS-1:0];
      cnt_r  <= in_occurrence_count;
    end
  end

  // Load one basis vector
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BASIS_MAX; i++) begin
        basis_r[i] <= '0;
      end
    end else if (cmd.load_basis) begin
      for (int i = 0; i < BASIS_MAX; i++) begin
        if (slot_r == SLOT_W'(i)) begin
          basis_r[i] <= sval_r;
        end
      end
    end
  end

  // Change of basis: one parity lane per basis vector in use
  assign bcount_eff = (bcount_r > BC_W'(BASIS_MAX)) ? BC_W'(BASIS_MAX) : bcount_r;

  always_comb begin
    for (int i = 0; i < BASIS_MAX; i++) begin
      tkey_nxt[i] = (BC_W'(i) < bcount_eff) & (^(basis_r[i] & sval_r));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.xform) begin
      tkey_r <= tkey_nxt;
    end
  end

  // Linear search: issue one read a cycle, compare the previous read
  assign more  = (rd_idx_r < used_r);
  assign hit   = cmp_vld_r && (key_rdata == tkey_r);
  assign issue = cmd.step && !hit && more;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_vld_r <= 1'b0;
    end else if (cmd.xform) begin
      cmp_vld_r <= 1'b0;
    end else if (cmd.step) begin
      cmp_vld_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.xform) begin
      rd_idx_r <= '0;
    end else if (issue) begin
      rd_idx_r  <= rd_idx_r + CW'(1);
      cmp_idx_r <= AW'(rd_idx_r);
    end
  end

  // Count of used entries
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (cmd.clear) begin
      used_r <= '0;
    end else if (cmd.append && (used_r < CW'(TABLE_DEPTH))) begin
      used_r <= used_r + CW'(1);
    end
  end

  // Table ports
  assign rd_en     = issue || cmd.read_issue;
  assign raddr     = cmd.read_issue ? AW'(slot_r) : AW'(rd_idx_r);
  assign key_we    = cmd.append && (used_r < CW'(TABLE_DEPTH));
  assign cnt_we    = key_we || cmd.update;
  assign waddr     = cmd.update ? cmp_idx_r : AW'(used_r);
  assign sum       = {1'b0, cnt_rdata} + {1'b0, cnt_r};
  assign sum_sat   = sum[COUNT_W] ? {COUNT_W{1'b1}} : sum[COUNT_W-1:0];
  assign cnt_wdata = cmd.update ? sum_sat : cnt_r;
  assign slot_ok   = (CMP_W'(slot_r) < CMP_W'(used_r));

  pbch_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (waddr),
    .wdata (tkey_r),
    .re    (rd_en),
    .raddr (raddr),
    .rdata (key_rdata)
  );

  pbch_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (waddr),
    .wdata (cnt_wdata),
    .re    (rd_en),
    .raddr (raddr),
    .rdata (cnt_rdata)
  );

  // Build the result of the item in work
  always_ff @(posedge clk) begin
    if (cmd.load_basis) begin
      res_tstate_r <= '0;
      res_idx_r    <= '0;
      res_key_r    <= '0;
      res_count_r  <= '0;
      res_status_r <= (slot_r < SLOT_W'(BASIS_MAX)) ? ST_OK : ST_RANGE;
    end else if (cmd.clear) begin
      res_tstate_r <= '0;
      res_idx_r    <= '0;
      res_key_r    <= '0;
      res_count_r  <= '0;
      res_status_r <= ST_OK;
    end else if (cmd.update) begin
      res_tstate_r <= tkey_r;
      res_idx_r    <= cmp_idx_r;
      res_key_r    <= tkey_r;
      res_count_r  <= sum_sat;
      res_status_r <= sum[COUNT_W] ? ST_SAT : ST_OK;
    end else if (cmd.append) begin
      res_tstate_r <= tkey_r;
      res_key_r    <= tkey_r;
      if (used_r < CW'(TABLE_DEPTH)) begin
        res_idx_r    <= AW'(used_r);
        res_count_r  <= cnt_r;
        res_status_r <= ST_OK;
      end else begin
        res_idx_r    <= '0;
        res_count_r  <= '0;
        res_status_r <= ST_FULL;
      end
    end else if (cmd.read_finish) begin
      res_tstate_r <= '0;
      if (slot_ok) begin
        res_idx_r    <= AW'(slot_r);
        res_key_r    <= key_rdata;
        res_count_r  <= cnt_rdata;
        res_status_r <= ST_OK;
      end else begin
        res_idx_r    <= '0;
        res_key_r    <= '0;
        res_count_r  <= '0;
        res_status_r <= ST_RANGE;
      end
    end
  end

  // Output register: hold while stalled, drop after it is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_tstate_r <= DATA_W'(res_tstate_r);
      out_idx_r    <= IDX_OUT_W'(res_idx_r);
      out_key_r    <= DATA_W'(res_key_r);
      out_count_r  <= res_count_r;
      out_used_r   <= USED_OUT_W'(used_r);
      out_status_r <= res_status_r;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_transformed_state = out_tstate_r;
  assign out_entry_index       = out_idx_r;
  assign out_entry_key         = out_key_r;
  assign out_entry_count       = out_count_r;
  assign out_entries_used      = out_used_r;
  assign out_status            = out_status_r;

  // Status to the controller
  assign sts.req      = req_r;
  assign sts.hit      = hit;
  assign sts.miss     = !cmp_vld_r && !more;
  assign sts.out_free = !out_valid_r || !out_stall;

endmodule

// ===== rtl/parity_basis_change_histogram.sv =====
// Top level of the parity basis change histogram: controller plus datapath.
//
// Usage:
// - Input channel (in_valid / in_stall): one request item at a time. Load
//   writes a basis vector, add maps a state into the new basis and counts
//   it in the key table, read returns one table entry, clear empties it.
// - Result channel (out_valid / out_stall): exactly one result item per
//   request, in request order.
// - cfg_wr_en / cfg_wr_data set the number of basis vectors in use; write
//   it only while no item is in work.
// - An add runs a linear key search that reads one table entry per cycle
//   from the key RAM until it finds the key or has covered every used
//   entry; load, clear and read need no search.
// - A new item is accepted the cycle after the previous one has moved into
//   the output register.
// - When the receiver stalls, the result is held in the output register;
//   the next item is still accepted and processed, and waits for the
//   output register to be free before it completes.
// - Reset empties the table and zeros the basis vectors and basis count;
//   no clearing pass is needed.
`timescale 1ns / 1ps

module parity_basis_change_histogram import pbch_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int BASIS_MAX   = BASIS_MAX_DEF,
  parameter int STATE_BITS  = STATE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [BC_W-1:0]       cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [REQ_W-1:0]      in_req_type,
  input  logic [SLOT_W-1:0]     in_slot,
  input  logic [DATA_W-1:0]     in_state_value,
  input  logic [COUNT_W-1:0]    in_occurrence_count,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DATA_W-1:0]     out_transformed_state,
  output logic [IDX_OUT_W-1:0]  out_entry_index,
  output logic [DATA_W-1:0]     out_entry_key,
  output logic [COUNT_W-1:0]    out_entry_count,
  output logic [USED_OUT_W-1:0] out_entries_used,
  output logic [STATUS_W-1:0]   out_status
);

  pbch_cmd_t cmd;
  pbch_sts_t sts;

  // Sequencer
  pbch_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Basis, tables and result registers
  pbch_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .BASIS_MAX   (BASIS_MAX),
    .STATE_BITS  (STATE_BITS)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_wr_data           (cfg_wr_data),
    .in_req_type           (in_req_type),
    .in_slot               (in_slot),
    .in_state_value        (in_state_value),
    .in_occurrence_count   (in_occurrence_count),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_transformed_state (out_transformed_state),
    .out_entry_index       (out_entry_index),
    .out_entry_key         (out_entry_key),
    .out_entry_count       (out_entry_count),
    .out_entries_used      (out_entries_used),
    .out_status            (out_status)
  );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the parity basis change histogram block.
`timescale 1ns / 1ps

module testbench;
  import pbch_pkg::*;

  // One request item as offered on the input channel
  typedef struct packed {
    req_t                 req;
    logic [SLOT_W-1:0]    slot;
    logic [DATA_W-1:0]    state;
    logic [COUNT_W-1:0]   count;
  } hist_req_t;

  // One result item as it should leave the block
  typedef struct packed {
    logic [DATA_W-1:0]     tstate;
    logic [IDX_OUT_W-1:0]  idx;
    logic [DATA_W-1:0]     key;
    logic [COUNT_W-1:0]    count;
    logic [USED_OUT_W-1:0] used;
    status_t               status;
  } hist_res_t;

  // Idle pattern of the two channels
  typedef enum int {PACE_TX31_RX66, PACE_TX66_RX31, PACE_NONE} pace_t;

  localparam int HOLD_CYCLES = 400;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [BC_W-1:0]       cfg_wr_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [REQ_W-1:0]      in_req_type = '0;
  logic [SLOT_W-1:0]     in_slot = '0;
  logic [DATA_W-1:0]     in_state_value = '0;
  logic [COUNT_W-1:0]    in_occurrence_count = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [DATA_W-1:0]     out_transformed_state;
  logic [IDX_OUT_W-1:0]  out_entry_index;
  logic [DATA_W-1:0]     out_entry_key;
  logic [COUNT_W-1:0]    out_entry_count;
  logic [USED_OUT_W-1:0] out_entries_used;
  logic [STATUS_W-1:0]   out_status;

  parity_basis_change_histogram dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_wr_data           (cfg_wr_data),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_req_type           (in_req_type),
    .in_slot               (in_slot),
    .in_state_value        (in_state_value),
    .in_occurrence_count   (in_occurrence_count),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_transformed_state (out_transformed_state),
    .out_entry_index       (out_entry_index),
    .out_entry_key         (out_entry_key),
    .out_entry_count       (out_entry_count),
    .out_entries_used      (out_entries_used),
    .out_status            (out_status)
  );

  // Mirror of the block state
  logic [DATA_W-1:0]  basis_vec [BASIS_MAX_DEF];
  logic [DATA_W-1:0]  key_col   [TABLE_DEPTH_DEF];
  logic [COUNT_W-1:0] count_col [TABLE_DEPTH_DEF];
  int                 used_cnt = 0;
  logic [BC_W-1:0]    basis_len = '0;

  hist_req_t pending_requests [$];
  hist_res_t due_results [$];
  hist_req_t cur_item;
  pace_t     pace = PACE_TX31_RX66;

  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;

  int mismatches = 0;
  int checked = 0;
  int accepted [4] = '{0, 0, 0, 0};
  int seen_sat = 0;
  int seen_range = 0;
  int seen_full = 0;
  int peak_used = 0;
  logic [DATA_W-1:0] recent_states [8];

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("testbench: FAIL");
    $finish;
  end

  // Map a state into the current basis: bit i is the parity of state AND vector i
  function automatic logic [DATA_W-1:0] rebase(input logic [DATA_W-1:0] s);
    int m;
    int i;
    logic [DATA_W-1:0] r;
    m = (basis_len > BASIS_MAX_DEF) ? BASIS_MAX_DEF : int'(basis_len);
    r = '0;
    for (i = 0; i < m; i++) r[i] = ^(basis_vec[i] & s);
    return r;
  endfunction

  // Apply one accepted request to the mirror and queue the result it owes
  task automatic histogram_apply(input hist_req_t r);
    hist_res_t e;
    int hit_at;
    int i;
    logic [COUNT_W:0] sum;
    e.tstate = '0;
    e.idx = '0;
    e.key = '0;
    e.count = '0;
    e.status = ST_OK;
    case (r.req)
      REQ_LOAD: begin
        if (r.slot < BASIS_MAX_DEF) basis_vec[r.slot] = r.state;
        else e.status = ST_RANGE;
      end
      REQ_ADD: begin
        e.tstate = rebase(r.state);
        e.key = e.tstate;
        hit_at = -1;
        for (i = 0; i < used_cnt && hit_at < 0; i++) begin
          if (key_col[i] == e.tstate) hit_at = i;
        end
        if (hit_at >= 0) begin
          sum = {1'b0, count_col[hit_at]} + {1'b0, r.count};
          if (sum[COUNT_W]) begin
            count_col[hit_at] = '1;
            e.status = ST_SAT;
          end else begin
            count_col[hit_at] = sum[COUNT_W-1:0];
          end
          e.idx = IDX_OUT_W'(hit_at);
          e.count = count_col[hit_at];
        end else if (used_cnt < TABLE_DEPTH_DEF) begin
          key_col[used_cnt] = e.tstate;
          count_col[used_cnt] = r.count;
          e.idx = IDX_OUT_W'(used_cnt);
          e.count = r.count;
          used_cnt++;
        end else begin
          e.status = ST_FULL;
        end
      end
      REQ_READ: begin
        if (r.slot < used_cnt) begin
          e.idx = r.slot;
          e.key = key_col[r.slot];
          e.count = count_col[r.slot];
        end else begin
          e.status = ST_RANGE;
        end
      end
      default: used_cnt = 0;
    endcase
    e.used = USED_OUT_W'(used_cnt);
    due_results = {due_results, e};
  endtask

  function automatic int tx_gap_pct(input pace_t p);
    case (p)
      PACE_TX31_RX66: return 31;
      PACE_TX66_RX31: return 66;
      default:        return 0;
    endcase
  endfunction

  function automatic int rx_stall_pct(input pace_t p);
    case (p)
      PACE_TX31_RX66: return 66;
      PACE_TX66_RX31: return 31;
      default:        return 0;
    endcase
  endfunction

  // Offer queued items; hold the payload while stalled
  always @(posedge clk) begin
    logic offer;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        histogram_apply(cur_item);
        accepted[cur_item.req]++;
      end
      if (!in_valid || !in_stall) begin
        offer = (pending_requests.size() != 0) &&
                ($urandom_range(0, 99) >= tx_gap_pct(pace));
        if (offer) begin
          cur_item = pending_requests.pop_front();
          in_req_type <= cur_item.req;
          in_slot <= cur_item.slot;
          in_state_value <= cur_item.state;
          in_occurrence_count <= cur_item.count;
        end
        in_valid <= offer;
      end
    end
  end

  // Count down a long receiver hold-off when one is requested
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_left <= HOLD_CYCLES;
      hold_served <= hold_requests;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Take results, compare them with the oldest due result, drive stall
  always @(posedge clk) begin
    hist_res_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        checked++;
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("testbench: result with nothing due: state %h idx %0d key %h cnt %h",
                     out_transformed_state, out_entry_index, out_entry_key, out_entry_count);
        end else begin
          want = due_results.pop_front();
          if (out_transformed_state !== want.tstate || out_entry_index !== want.idx ||
              out_entry_key !== want.key || out_entry_count !== want.count ||
              out_entries_used !== want.used || out_status !== want.status) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display({"testbench: mismatch at %0t: want state %h idx %0d key %h",
                        " cnt %h used %0d st %0d"},
                       $realtime, want.tstate, want.idx, want.key, want.count, want.used,
                       want.status);
              $display({"testbench:   got            state %h idx %0d key %h",
                        " cnt %h used %0d st %0d"},
                       out_transformed_state, out_entry_index, out_entry_key,
                       out_entry_count, out_entries_used, out_status);
            end
          end
        end
        if (out_status == ST_SAT) seen_sat++;
        if (out_status == ST_RANGE) seen_range++;
        if (out_status == ST_FULL) seen_full++;
        if (out_entries_used > peak_used) peak_used = out_entries_used;
      end
      out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < rx_stall_pct(pace));
    end
  end

  task automatic push_req(input req_t rq, input int slot, input logic [DATA_W-1:0] st,
                          input logic [COUNT_W-1:0] ct);
    hist_req_t r;
    r.req = rq;
    r.slot = SLOT_W'(slot);
    r.state = st;
    r.count = ct;
    pending_requests = {pending_requests, r};
  endtask

  // Advance until every item is taken and every result has come back
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_requests.size() != 0 || in_valid || due_results.size() != 0);
  endtask

  // Write the basis count register; only called while the block is idle
  task automatic set_basis_len(input logic [BC_W-1:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    basis_len = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // Random mix: repeated states to hit known keys, counts near the top to saturate
  task automatic queue_random(input int n);
    int k;
    int pick;
    logic [DATA_W-1:0] st;
    logic [COUNT_W-1:0] ct;
    for (k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 3))
        0: st = $urandom;
        1: st = '0;
        2: st = '1;
        default: st = 32'h1 << $urandom_range(0, 31);
      endcase
      case ($urandom_range(0, 3))
        0: ct = $urandom;
        1: ct = $urandom_range(0, 15);
        2: ct = 32'hFFFF_FFFF - $urandom_range(0, 15);
        default: ct = {8'($urandom_range(0, 255)), 24'h0};
      endcase
      if (pick < 15) begin
        push_req(REQ_LOAD, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                                        : $urandom_range(0, 31), st, ct);
      end else if (pick < 70) begin
        if ($urandom_range(0, 1) == 0) st = recent_states[$urandom_range(0, 7)];
        else if ($urandom_range(0, 1) == 0) st = $urandom;
        recent_states[$urandom_range(0, 7)] = st;
        push_req(REQ_ADD, $urandom_range(0, 1023), st, ct);
      end else if (pick < 92) begin
        push_req(REQ_READ, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023)
                                                       : $urandom_range(0, 40), st, ct);
      end else begin
        push_req(REQ_CLEAR, $urandom_range(0, 1023), st, ct);
      end
    end
  endtask

  initial begin
    int i;
    logic [21:0] hi;
    logic [DATA_W-1:0] first_fill;
    logic [DATA_W-1:0] last_fill;
    for (i = 0; i < BASIS_MAX_DEF; i++) basis_vec[i] = '0;
    for (i = 0; i < 8; i++) recent_states[i] = $urandom;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: extremes, range errors, saturation, reads around the used count
    set_basis_len(6'd32);
    push_req(REQ_ADD, 0, 32'hFFFF_FFFF, 32'd5);
    push_req(REQ_LOAD, 0, 32'hFFFF_FFFF, 32'd0);
    push_req(REQ_LOAD, 31, 32'h8000_0001, 32'd0);
    push_req(REQ_LOAD, 32, 32'h0000_1234, 32'd0);
    push_req(REQ_LOAD, 1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_req(REQ_LOAD, 5, 32'h0000_00FF, 32'd0);
    push_req(REQ_ADD, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_req(REQ_ADD, 1023, 32'h0000_0001, 32'd0);
    push_req(REQ_ADD, 0, 32'h0000_0001, 32'hFFFF_FFFF);
    push_req(REQ_ADD, 0, 32'h0000_0001, 32'd1);
    push_req(REQ_ADD, 0, 32'h0000_0000, 32'hFFFF_FFFF);
    push_req(REQ_READ, 0, 32'd0, 32'd0);
    push_req(REQ_READ, 1, 32'd0, 32'd0);
    push_req(REQ_READ, 2, 32'd0, 32'd0);
    push_req(REQ_READ, 1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_req(REQ_CLEAR, 0, 32'd0, 32'd0);
    push_req(REQ_READ, 0, 32'd0, 32'd0);
    push_req(REQ_ADD, 0, 32'h8000_0000, 32'hFFFF_FFFF);
    push_req(REQ_ADD, 0, 32'h7FFF_FFFF, 32'd1);
    push_req(REQ_CLEAR, 1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_req(REQ_LOAD, 0, 32'd0, 32'd0);
    wait_drained();

    // Zero-width basis: every add maps to key zero
    set_basis_len(6'd0);
    queue_random(100);
    wait_drained();

    // Oversized basis count acts as the full basis; sender pauses mid-phase
    pace = PACE_TX66_RX31;
    set_basis_len(6'd63);
    queue_random(50);
    wait_drained();
    queue_random(50);
    wait_drained();

    set_basis_len(6'd7);
    queue_random(80);
    wait_drained();

    // No idling; hold the receiver off so the block backs up into the input
    pace = PACE_NONE;
    set_basis_len(6'd20);
    hold_requests++;
    queue_random(100);
    wait_drained();

    // Grow the table with distinct keys, then add one new and one known key
    set_basis_len(6'd32);
    for (i = 0; i < BASIS_MAX_DEF; i++) push_req(REQ_LOAD, i, 32'h1 << i, $urandom);
    push_req(REQ_CLEAR, 0, 32'd0, 32'd0);
    for (i = 0; i < 140; i++) begin
      hi = 22'($urandom);
      last_fill = {hi, 10'(i)};
      if (i == 0) first_fill = last_fill;
      push_req(REQ_ADD, $urandom_range(0, 1023), last_fill, $urandom);
    end
    push_req(REQ_ADD, 0, first_fill ^ 32'h8000_0000, 32'd7);
    push_req(REQ_ADD, 0, last_fill, $urandom | 32'h8000_0001);
    push_req(REQ_READ, 1023, 32'd0, 32'd0);
    push_req(REQ_READ, 0, 32'd0, 32'd0);
    push_req(REQ_CLEAR, 0, 32'd0, 32'd0);
    push_req(REQ_READ, 0, 32'd0, 32'd0);
    wait_drained();

    repeat (20) @(posedge clk);
    $display("testbench: %0d items taken (load %0d, add %0d, read %0d, clear %0d)",
             accepted[0] + accepted[1] + accepted[2] + accepted[3], accepted[REQ_LOAD],
             accepted[REQ_ADD], accepted[REQ_READ], accepted[REQ_CLEAR]);
    $display({"testbench: %0d results checked, %0d saturated, %0d out of range,",
              " %0d dropped on full table, peak %0d keys"},
             checked, seen_sat, seen_range, seen_full, peak_used);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
